// ===== rtl/first_fit_boundary_tag_allocator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// ffba assertion macros
// Shared concurrent assertion forms for the allocator, clocked on clk and
// held off during rst.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BOUNDARY_TAG_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_BOUNDARY_TAG_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define FFBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ffba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and constants shared by the boundary-tag allocator modules.
// ----------------------------------------------------------------------------
package ffba_pkg;

  // byte offsets, sizes and tag words all fit this datapath
  localparam int DW = 18;

  localparam logic [DW-1:0] TAG_MASK  = DW'(7);
  localparam logic [DW-1:0] USED_BIT  = DW'(1);
  localparam logic [DW-1:0] MIN_BLOCK = DW'(16);

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_OOM     = 2'd2;

  typedef logic [DW-1:0] word_t;

  // constant adjustment applied by the address adder
  typedef enum logic [1:0] {
    ADJ_NONE,
    ADJ_M4,
    ADJ_M8
  } adj_t;

  typedef struct packed {
    logic sub;
    adj_t adj;
  } alu_op_t;

endpackage

// ===== rtl/ffba_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_alu
// Shared offset adder: a plus or minus b, then a small constant adjustment.
// ----------------------------------------------------------------------------
module ffba_alu (
  input  ffba_pkg::word_t   a,
  input  ffba_pkg::word_t   b,
  input  ffba_pkg::alu_op_t op,
  output ffba_pkg::word_t   res
);
  import ffba_pkg::*;

  word_t opb;
  word_t adj;

  // operand select and adjustment constant
  always_comb begin
    opb = op.sub ? (~b + DW'(1)) : b;
    unique case (op.adj)
      ADJ_NONE: adj = '0;
      ADJ_M4:   adj = ~DW'(4) + DW'(1);
      ADJ_M8:   adj = ~DW'(8) + DW'(1);
      default:  adj = '0;
    endcase
  end

  assign res = a + opb + adj;

endmodule

// ===== rtl/ffba_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_mem
// Heap word memory, one shared address, write plus registered read.
// ----------------------------------------------------------------------------
module ffba_mem #(
  parameter int DEPTH = 16384
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ffba_pkg::DW-3:0] idx,
  input  ffba_pkg::word_t      wdata,
  output ffba_pkg::word_t      rdata
);
  import ffba_pkg::*;

  localparam int AW = $clog2(DEPTH);

  word_t mem [DEPTH];
  logic  in_range;

  assign in_range = (idx < (DW-2)'(DEPTH));

  // write drops out-of-range words, read of them gives zero
  always_ff @(posedge clk) begin
    if (we && in_range) begin
      mem[idx[AW-1:0]] <= wdata;
    end
    rdata <= in_range ? mem[idx[AW-1:0]] : '0;
  end

endmodule

// ===== rtl/first_fit_boundary_tag_allocator_unit.sv =====
`timescale 1ns / 1ps
// Sequence: allocate walks the block headers first-fit, then grows the heap
// if no block fits, merges, splits and posts the result; free walks the
// blocks up to the given offset, then retags, merges and posts.
// Flow: one item at a time, set by the walk through the single heap
// memory port; a held result delays the next one in its last step.
// Reset: after rst the initial heap is laid out before any item is taken.
// ----------------------------------------------------------------------------
// first_fit_boundary_tag_allocator_unit
// First-fit heap allocator with boundary tags, sequenced over one memory port
// and one shared offset adder.
// ----------------------------------------------------------------------------
module first_fit_boundary_tag_allocator_unit #(
  parameter int HEAP_WORDS  = 16384,
  parameter int CHUNK_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] request_bytes, [31:16] free_offset
  input  logic        s_tuser,   // [0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] block_offset
  output logic [1:0]  m_tuser    // [1:0] status
);
  import ffba_pkg::*;

  localparam int    CH_SZ     = (((CHUNK_BYTES / 4) + 1) / 2) * 8;
  localparam bit    INIT_FITS = (CH_SZ <= HEAP_WORDS * 4 - 16);
  localparam word_t HB        = DW'(HEAP_WORDS * 4);
  localparam word_t CHUNK     = DW'(CHUNK_BYTES);
  localparam word_t INIT_BRK  = INIT_FITS ? DW'(16 + CH_SZ) : DW'(16);
  localparam logic [2:0] INIT_LAST = INIT_FITS ? 3'd4 : 3'd2;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE,
    S_FW_RD, S_FW_CHK, S_GROW, S_GW1, S_GW2, S_GW3,
    S_JN_H, S_JN_F, S_JN_N, S_JN_X, S_JW1, S_JW2,
    S_TK_RD, S_TK_CHK, S_TK_F, S_TK_R1, S_TK_R2,
    S_FR_RD, S_FR_CHK, S_FF1, S_FF2, S_DONE
  } state_t;

  state_t     state;
  logic [2:0] init_cnt;
  logic       act;
  word_t      need, off, p, sz, prevsz, have, tk_sz, brk;
  logic       prev_used, tk_split;
  logic [15:0] res_blk;
  logic [1:0]  res_status;

  word_t   alu_a, alu_b, alu_res, mem_wdata, mem_rdata;
  alu_op_t alu_op;
  logic    mem_we;
  word_t   rd_sz, need_in, ext, gsz;
  logic    rd_used;

  ffba_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .op  (alu_op),
    .res (alu_res)
  );

  ffba_mem #(.DEPTH(HEAP_WORDS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .idx   (alu_res[DW-1:2]),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign s_tready = (state == S_IDLE);
  assign rd_sz    = mem_rdata & ~TAG_MASK;
  assign rd_used  = mem_rdata[0];

  // block size for a request, and the growth amount for it
  always_comb begin
    need_in = (s_tdata[15:0] <= 16'd8) ? MIN_BLOCK
            : ((DW'(s_tdata[15:0]) + DW'(15)) & ~TAG_MASK);
    ext     = (need > CHUNK) ? need : CHUNK;
    gsz     = ((ext >> 3) + DW'(ext[2])) << 3;
  end

  // address and write data per step
  always_comb begin
    alu_a     = p;
    alu_b     = '0;
    alu_op    = '{sub: 1'b0, adj: ADJ_NONE};
    mem_we    = 1'b0;
    mem_wdata = sz;
    unique case (state)
      S_INIT: begin
        mem_we = 1'b1;
        unique case (init_cnt)
          3'd0: begin alu_a = DW'(4);  mem_wdata = DW'(8) | USED_BIT; end
          3'd1: begin alu_a = DW'(8);  mem_wdata = DW'(8) | USED_BIT; end
          3'd2: begin
            alu_a     = DW'(12);
            mem_wdata = INIT_FITS ? DW'(CH_SZ) : USED_BIT;
          end
          3'd3: begin alu_a = DW'(16 + CH_SZ - 8); mem_wdata = DW'(CH_SZ); end
          default: begin alu_a = DW'(16 + CH_SZ - 4); mem_wdata = USED_BIT; end
        endcase
      end
      S_FW_RD, S_FR_RD, S_JN_H, S_TK_RD: alu_op.adj = ADJ_M4;
      S_FW_CHK, S_FR_CHK: alu_b = rd_sz;
      S_JN_F: alu_op.adj = ADJ_M8;
      S_JN_N: begin alu_b = sz; alu_op.adj = ADJ_M4; end
      S_JN_X: begin alu_b = prevsz; alu_op.sub = 1'b1; end
      S_GW1, S_JW1, S_FF1: begin alu_op.adj = ADJ_M4; mem_we = 1'b1; end
      S_GW2, S_JW2, S_FF2: begin
        alu_b = sz; alu_op.adj = ADJ_M8; mem_we = 1'b1;
      end
      S_GW3: begin
        alu_b = sz; alu_op.adj = ADJ_M4; mem_we = 1'b1; mem_wdata = USED_BIT;
      end
      S_TK_CHK: begin
        alu_op.adj = ADJ_M4;
        mem_we     = 1'b1;
        mem_wdata  = ((rd_sz >= need + MIN_BLOCK) ? need : rd_sz) | USED_BIT;
      end
      S_TK_F: begin
        alu_b = tk_sz; alu_op.adj = ADJ_M8; mem_we = 1'b1;
        mem_wdata = tk_sz | USED_BIT;
      end
      S_TK_R1: begin
        alu_b = need; alu_op.adj = ADJ_M4; mem_we = 1'b1;
        mem_wdata = have - need;
      end
      S_TK_R2: begin
        alu_b = have; alu_op.adj = ADJ_M8; mem_we = 1'b1;
        mem_wdata = have - need;
      end
      default: alu_a = p;
    endcase
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      init_cnt <= '0;
      brk      <= INIT_BRK;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          init_cnt <= init_cnt + 3'd1;
          if (init_cnt == INIT_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            act        <= s_tuser;
            need       <= need_in;
            off        <= DW'(s_tdata[31:16]);
            res_blk    <= '0;
            res_status <= ST_OK;
            if (s_tuser == ACT_FREE) begin
              p     <= DW'(16);
              state <= S_FR_RD;
            end else if (s_tdata[15:0] == 16'd0) begin
              res_status <= ST_IGNORED;
              state      <= S_DONE;
            end else begin
              p     <= DW'(8);
              state <= S_FW_RD;
            end
          end
        end
        // first-fit walk
        S_FW_RD: state <= S_FW_CHK;
        S_FW_CHK: begin
          if (rd_sz == '0) begin
            state <= S_GROW;
          end else if (!rd_used && need <= rd_sz) begin
            state <= S_TK_RD;
          end else begin
            p     <= alu_res;
            state <= (alu_res >= HB) ? S_GROW : S_FW_RD;
          end
        end
        // heap growth
        S_GROW: begin
          if (brk + gsz > HB) begin
            res_status <= ST_OOM;
            state      <= S_DONE;
          end else begin
            p     <= brk;
            sz    <= gsz;
            brk   <= brk + gsz;
            state <= S_GW1;
          end
        end
        S_GW1: state <= S_GW2;
        S_GW2: state <= S_GW3;
        S_GW3: state <= S_JN_H;
        // merge with free neighbors
        S_JN_H: state <= S_JN_F;
        S_JN_F: begin
          sz    <= rd_sz;
          state <= S_JN_N;
        end
        S_JN_N: begin
          prevsz    <= rd_sz;
          prev_used <= rd_used;
          state     <= S_JN_X;
        end
        S_JN_X: begin
          if (prev_used && rd_used) begin
            state <= (act == ACT_ALLOC) ? S_TK_RD : S_DONE;
          end else if (prev_used) begin
            sz    <= sz + rd_sz;
            state <= S_JW1;
          end else begin
            p     <= alu_res;
            sz    <= sz + prevsz + (rd_used ? '0 : rd_sz);
            state <= S_JW1;
          end
        end
        S_JW1: state <= S_JW2;
        S_JW2: state <= (act == ACT_ALLOC) ? S_TK_RD : S_DONE;
        // place and split
        S_TK_RD: state <= S_TK_CHK;
        S_TK_CHK: begin
          have     <= rd_sz;
          tk_split <= (rd_sz >= need + MIN_BLOCK);
          tk_sz    <= (rd_sz >= need + MIN_BLOCK) ? need : rd_sz;
          state    <= S_TK_F;
        end
        S_TK_F: begin
          if (tk_split) begin
            state <= S_TK_R1;
          end else begin
            res_blk <= p[15:0];
            state   <= S_DONE;
          end
        end
        S_TK_R1: state <= S_TK_R2;
        S_TK_R2: begin
          res_blk <= p[15:0];
          state   <= S_DONE;
        end
        // free: locate the live block
        S_FR_RD: state <= S_FR_CHK;
        S_FR_CHK: begin
          if (rd_sz == '0 || p > off) begin
            res_status <= ST_IGNORED;
            state      <= S_DONE;
          end else if (p == off) begin
            if (rd_used) begin
              sz    <= rd_sz;
              state <= S_FF1;
            end else begin
              res_status <= ST_IGNORED;
              state      <= S_DONE;
            end
          end else begin
            p <= alu_res;
            if (alu_res >= HB) begin
              res_status <= ST_IGNORED;
              state      <= S_DONE;
            end else begin
              state <= S_FR_RD;
            end
          end
        end
        S_FF1: state <= S_FF2;
        S_FF2: state <= S_JN_H;
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res_blk;
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "first_fit_boundary_tag_allocator_unit_assert.svh"

  `FFBA_ASSERT_NOW(a_status_code, m_tvalid, m_tuser != 2'd3, "bad status code")
  `FFBA_ASSERT_NOW(a_fail_zero, m_tvalid && m_tuser == ST_OOM, m_tdata == 16'd0, "failed item carries offset")
  `FFBA_ASSERT_NOW(a_align, m_tvalid, m_tdata[2:0] == 3'd0, "offset not 8-byte aligned")
  `FFBA_ASSERT_NOW(a_brk_cap, state != S_INIT, brk <= HB, "break beyond heap")
  `FFBA_ASSERT_NOW(a_idle_nowrite, state == S_IDLE, !mem_we, "heap written while idle")
  `FFBA_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, !s_tready, "second item taken at once")

endmodule
